/* rtl/sm64_pkg.sv */
// splitmix64 range generator: shared types, constants and the sequencer program
// depends on nothing; imported by splitmix64_range_generator and its testbench
`default_nettype none

package sm64_pkg;

	localparam logic [63:0] GOLDEN_STEP = 64'h9E3779B97F4A7C15;
	localparam logic [63:0] MIX_MUL_A   = 64'hBF58476D1CE4E5B9;
	localparam logic [63:0] MIX_MUL_B   = 64'h94D049BB133111EB;
	localparam int unsigned SHIFT_1    = 30;
	localparam int unsigned SHIFT_2    = 27;
	localparam int unsigned SHIFT_3    = 31;
	localparam int unsigned FRAC_SHIFT = 40;

	localparam logic [1:0] F_RAW   = 2'd0;
	localparam logic [1:0] F_UNIT  = 2'd1;
	localparam logic [1:0] F_RANGE = 2'd2;
	localparam logic [1:0] F_LOAD  = 2'd3;

	localparam logic [5:0] DIV_LAST = 6'd63;

	typedef logic [4:0] pc_t;

	localparam pc_t P_WAIT     = 5'd0;
	localparam pc_t P_DECODE   = 5'd1;
	localparam pc_t P_RCHK     = 5'd2;
	localparam pc_t P_DIV1     = 5'd3;
	localparam pc_t P_SETLIM   = 5'd4;
	localparam pc_t P_DRAW     = 5'd5;
	localparam pc_t P_MA0      = 5'd6;
	localparam pc_t P_MA1      = 5'd7;
	localparam pc_t P_MA2      = 5'd8;
	localparam pc_t P_XS27     = 5'd9;
	localparam pc_t P_MB0      = 5'd10;
	localparam pc_t P_MB1      = 5'd11;
	localparam pc_t P_MB2      = 5'd12;
	localparam pc_t P_XS31     = 5'd13;
	localparam pc_t P_REJ      = 5'd14;
	localparam pc_t P_DIV2     = 5'd15;
	localparam pc_t P_RANGEOUT = 5'd16;
	localparam pc_t P_LOAD     = 5'd17;
	localparam pc_t P_ERR      = 5'd18;
	localparam pc_t P_OUT      = 5'd19;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_CAPTURE,
		OP_RINIT,
		OP_DIV,
		OP_SETLIM,
		OP_ADVANCE,
		OP_MUL0,
		OP_MUL1,
		OP_MUL2,
		OP_XS27,
		OP_XS31,
		OP_DINIT,
		OP_RANGEOUT,
		OP_LOAD,
		OP_ERR,
		OP_PUSH
	} dp_op_t;

	typedef enum logic [3:0] {
		J_NEXT,
		J_ALWAYS,
		J_ACCEPT,
		J_FUNC,
		J_ERR,
		J_LOOP,
		J_NOTRANGE,
		J_REJ,
		J_PUSH
	} jmp_t;

	typedef struct packed {
		dp_op_t op;
		jmp_t   jmp;
		logic   csel;     // 0 first multiplier constant, 1 second
		pc_t    target;
	} ctrl_t;

	function automatic ctrl_t ucode(input pc_t pc);
		ctrl_t w;
		w = '{op: OP_NONE, jmp: J_ALWAYS, csel: 1'b0, target: P_WAIT};
		case (pc)
			P_WAIT:     w = '{op: OP_CAPTURE,  jmp: J_ACCEPT,   csel: 1'b0, target: P_DECODE};
			P_DECODE:   w = '{op: OP_NONE,     jmp: J_FUNC,     csel: 1'b0, target: P_WAIT};
			P_RCHK:     w = '{op: OP_RINIT,    jmp: J_ERR,      csel: 1'b0, target: P_ERR};
			P_DIV1:     w = '{op: OP_DIV,      jmp: J_LOOP,     csel: 1'b0, target: P_DIV1};
			P_SETLIM:   w = '{op: OP_SETLIM,   jmp: J_NEXT,     csel: 1'b0, target: P_WAIT};
			P_DRAW:     w = '{op: OP_ADVANCE,  jmp: J_NEXT,     csel: 1'b0, target: P_WAIT};
			P_MA0:      w = '{op: OP_MUL0,     jmp: J_NEXT,     csel: 1'b0, target: P_WAIT};
			P_MA1:      w = '{op: OP_MUL1,     jmp: J_NEXT,     csel: 1'b0, target: P_WAIT};
			P_MA2:      w = '{op: OP_MUL2,     jmp: J_NEXT,     csel: 1'b0, target: P_WAIT};
			P_XS27:     w = '{op: OP_XS27,     jmp: J_NEXT,     csel: 1'b0, target: P_WAIT};
			P_MB0:      w = '{op: OP_MUL0,     jmp: J_NEXT,     csel: 1'b1, target: P_WAIT};
			P_MB1:      w = '{op: OP_MUL1,     jmp: J_NEXT,     csel: 1'b1, target: P_WAIT};
			P_MB2:      w = '{op: OP_MUL2,     jmp: J_NEXT,     csel: 1'b1, target: P_WAIT};
			P_XS31:     w = '{op: OP_XS31,     jmp: J_NOTRANGE, csel: 1'b0, target: P_OUT};
			P_REJ:      w = '{op: OP_DINIT,    jmp: J_REJ,      csel: 1'b0, target: P_DRAW};
			P_DIV2:     w = '{op: OP_DIV,      jmp: J_LOOP,     csel: 1'b0, target: P_DIV2};
			P_RANGEOUT: w = '{op: OP_RANGEOUT, jmp: J_ALWAYS,   csel: 1'b0, target: P_OUT};
			P_LOAD:     w = '{op: OP_LOAD,     jmp: J_ALWAYS,   csel: 1'b0, target: P_OUT};
			P_ERR:      w = '{op: OP_ERR,      jmp: J_ALWAYS,   csel: 1'b0, target: P_OUT};
			P_OUT:      w = '{op: OP_PUSH,     jmp: J_PUSH,     csel: 1'b0, target: P_WAIT};
			default:    w = '{op: OP_NONE,     jmp: J_ALWAYS,   csel: 1'b0, target: P_WAIT};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

/* rtl/splitmix64_range_generator.sv */
// range draws run two 64-step remainder loops, one for the rejection limit and one to
// reduce the accepted draw; a draw at or above the limit is redrawn
// each 64-bit multiply is built from three 32x32 partial products
// one beat in flight; the next beat can be taken in the cycle after the result is registered
// reset clears the generator state to zero and returns the sequencer to its wait step
// splitmix64 generator: raw, fraction and range draws, seed load; microcoded from sm64_pkg
`default_nettype none

module splitmix64_range_generator
	import sm64_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  func,
	input  wire logic [31:0] range_low,
	input  wire logic [31:0] range_high,
	input  wire logic [63:0] load_value,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [63:0]      result_value,
	output logic             range_error
);

	pc_t         pc_q;
	ctrl_t       cw;
	logic        accept;
	logic        push_ok;
	logic        out_valid_q;
	logic [63:0] result_value_q;
	logic        range_error_q;

	logic [1:0]  func_q;
	logic [31:0] lo_q;
	logic [31:0] hi_q;
	logic [63:0] load_q;
	logic [63:0] st_q;
	logic [63:0] z_q;
	logic [63:0] acc_q;
	logic [63:0] lim_q;
	logic [63:0] dvd_q;
	logic [32:0] rem_q;
	logic [32:0] span_q;
	logic [5:0]  cnt_q;
	logic [63:0] res_q;
	logic        err_q;

	logic [63:0] adv;
	logic [63:0] fin;
	logic [63:0] mconst;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] prod;
	logic [33:0] shifted;
	logic [33:0] diff;
	logic        hi_below_lo;
	logic        reject;
	pc_t         pc_next;

	assign cw          = ucode(pc_q);
	assign in_stall    = (pc_q != P_WAIT);
	assign accept      = in_valid && !in_stall;
	assign push_ok     = !out_valid_q || !out_stall;
	assign out_valid   = out_valid_q;
	assign result_value = result_value_q;
	assign range_error = range_error_q;

	assign hi_below_lo = (hi_q < lo_q);
	assign reject      = (z_q >= lim_q);

	// datapath
	assign adv    = st_q + GOLDEN_STEP;
	assign fin    = acc_q ^ (acc_q >> SHIFT_3);
	assign mconst = cw.csel ? MIX_MUL_B : MIX_MUL_A;
	assign mul_a  = (cw.op == OP_MUL2) ? z_q[63:32] : z_q[31:0];
	assign mul_b  = (cw.op == OP_MUL1) ? mconst[63:32] : mconst[31:0];
	assign prod   = {32'd0, mul_a} * {32'd0, mul_b};

	assign shifted = {rem_q, dvd_q[63]};
	assign diff    = shifted - {1'b0, span_q};

	// sequencer
	always_comb begin
		pc_next = pc_q + 5'd1;
		case (cw.jmp)
			J_NEXT:     pc_next = pc_q + 5'd1;
			J_ALWAYS:   pc_next = cw.target;
			J_ACCEPT:   pc_next = accept ? cw.target : pc_q;
			J_FUNC: begin
				case (func_q)
					F_RAW:   pc_next = P_DRAW;
					F_UNIT:  pc_next = P_DRAW;
					F_RANGE: pc_next = P_RCHK;
					F_LOAD:  pc_next = P_LOAD;
					default: pc_next = P_LOAD;
				endcase
			end
			J_ERR:      pc_next = hi_below_lo ? cw.target : pc_q + 5'd1;
			J_LOOP:     pc_next = (cnt_q != DIV_LAST) ? cw.target : pc_q + 5'd1;
			J_NOTRANGE: pc_next = (func_q != F_RANGE) ? cw.target : pc_q + 5'd1;
			J_REJ:      pc_next = reject ? cw.target : pc_q + 5'd1;
			J_PUSH:     pc_next = push_ok ? cw.target : pc_q;
			default:    pc_next = P_WAIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= P_WAIT;
			out_valid_q <= 1'b0;
			st_q        <= '0;
		end else begin
			pc_q <= pc_next;
			if (cw.op == OP_PUSH && push_ok) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (cw.op)
				OP_ADVANCE: st_q <= adv;
				OP_LOAD:    st_q <= load_q;
				default:    st_q <= st_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cw.op)
			OP_CAPTURE: begin
				if (accept) begin
					func_q <= func;
					lo_q   <= range_low;
					hi_q   <= range_high;
					load_q <= load_value;
				end
			end
			OP_RINIT: begin
				span_q <= {1'b0, hi_q} - {1'b0, lo_q} + 33'd1;
				dvd_q  <= '1;
				rem_q  <= '0;
				cnt_q  <= '0;
			end
			OP_DIV: begin
				rem_q <= diff[33] ? shifted[32:0] : diff[32:0];
				dvd_q <= {dvd_q[62:0], 1'b0};
				cnt_q <= cnt_q + 6'd1;
			end
			OP_SETLIM: lim_q <= 64'hFFFF_FFFF_FFFF_FFFF - {31'd0, rem_q};
			OP_ADVANCE: z_q <= adv ^ (adv >> SHIFT_1);
			OP_MUL0: acc_q <= prod;
			OP_MUL1: acc_q <= acc_q + {prod[31:0], 32'd0};
			OP_MUL2: acc_q <= acc_q + {prod[31:0], 32'd0};
			OP_XS27: z_q <= acc_q ^ (acc_q >> SHIFT_2);
			OP_XS31: begin
				z_q   <= fin;
				res_q <= (func_q == F_UNIT) ? (fin >> FRAC_SHIFT) : fin;
				err_q <= 1'b0;
			end
			OP_DINIT: begin
				dvd_q <= z_q;
				rem_q <= '0;
				cnt_q <= '0;
			end
			OP_RANGEOUT: begin
				res_q <= {32'd0, lo_q} + {31'd0, rem_q};
				err_q <= 1'b0;
			end
			OP_LOAD: begin
				res_q <= '0;
				err_q <= 1'b0;
			end
			OP_ERR: begin
				res_q <= '0;
				err_q <= 1'b1;
			end
			OP_PUSH: begin
				if (push_ok) begin
					result_value_q <= res_q;
					range_error_q  <= err_q;
				end
			end
			default: begin
			end
		endcase
	end

	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (pc_q == P_DECODE))
		else $error("accepted beat did not reach decode");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		((pc_q == P_DIV1) || (pc_q == P_DIV2) || (pc_q == P_SETLIM) ||
		 (pc_q == P_RANGEOUT)) |-> (rem_q < span_q))
		else $error("remainder not below span");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> ($past(pc_q) == P_OUT))
		else $error("output beat raised outside the output step");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && range_error) |-> (result_value == 64'd0))
		else $error("range error beat carries a nonzero value");

endmodule

`default_nettype wire

/* dv/splitmix64_range_generator_tb.sv */
// testbench for splitmix64_range_generator: directed and random raw, unit, range and load beats
// checked against an in-bench splitmix64 predictor under random idle on both channels
// depends on sm64_pkg and the generator rtl
`timescale 1ns / 100ps

module splitmix64_range_generator_tb
	import sm64_pkg::*;
();

	localparam logic [63:0] STEP_INC  = 64'h9E3779B97F4A7C15;
	localparam logic [63:0] MIX_A     = 64'hBF58476D1CE4E5B9;
	localparam logic [63:0] MIX_B     = 64'h94D049BB133111EB;
	localparam logic [63:0] ALL_ONES  = 64'hFFFFFFFFFFFFFFFF;
	localparam int          MAX_CYCLES = 1000000;
	localparam int          TAIL_CYCLES = 300;

	typedef struct {
		logic [1:0]  op;
		logic [31:0] lo;
		logic [31:0] hi;
		logic [63:0] seed;
		bit          drain;
	} gen_req_t;

	typedef struct packed {
		logic [63:0] value;
		logic        err;
	} answer_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  func = F_RAW;
	logic [31:0] range_low = '0;
	logic [31:0] range_high = '0;
	logic [63:0] load_value = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [63:0] result_value;
	logic        range_error;

	gen_req_t    request_queue[$];
	answer_t     pending_answers[$];
	logic [63:0] gen_state = '0;
	logic        in_taken = 1'b0;
	int          cycles = 0;
	int          errors = 0;
	int          n_accepted = 0;
	int          n_checked = 0;
	int          n_op[4] = '{0, 0, 0, 0};
	int          n_range_err = 0;
	int          n_redraws = 0;

	wire calm = (n_accepted >= 300) && (n_accepted < 420);

	splitmix64_range_generator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.func         (func),
		.range_low    (range_low),
		.range_high   (range_high),
		.load_value   (load_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_value (result_value),
		.range_error  (range_error)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [63:0] next_draw();
		logic [63:0] z;
		gen_state = gen_state + STEP_INC;
		z = gen_state;
		z = (z ^ (z >> 30)) * MIX_A;
		z = (z ^ (z >> 27)) * MIX_B;
		return z ^ (z >> 31);
	endfunction

	function automatic answer_t answer_for(input logic [1:0] op, input logic [31:0] lo,
			input logic [31:0] hi, input logic [63:0] seed);
		answer_t     a;
		logic [63:0] span;
		logic [63:0] limit;
		logic [63:0] v;
		a = '{value: '0, err: 1'b0};
		case (op)
			F_RAW: begin
				a.value = next_draw();
			end
			F_UNIT: begin
				a.value = next_draw() >> 40;
			end
			F_RANGE: begin
				if (hi < lo) begin
					a.err = 1'b1;
				end else begin
					span = {32'd0, hi} - {32'd0, lo} + 64'd1;
					limit = ALL_ONES - (ALL_ONES % span);
					v = next_draw();
					while (v >= limit) begin
						n_redraws++;
						v = next_draw();
					end
					a.value = {32'd0, lo} + (v % span);
				end
			end
			default: begin
				gen_state = seed;
			end
		endcase
		return a;
	endfunction

	// inverse of x ^ (x >> k)
	function automatic logic [63:0] unshift(input logic [63:0] y, input int k);
		logic [63:0] x;
		x = y;
		for (int i = 0; i < 3; i++)
			x = y ^ (x >> k);
		return x;
	endfunction

	function automatic logic [63:0] odd_inverse(input logic [63:0] a);
		logic [63:0] x;
		x = a;
		for (int i = 0; i < 6; i++)
			x = x * (64'd2 - a * x);
		return x;
	endfunction

	task automatic add_req(input logic [1:0] op, input logic [31:0] lo, input logic [31:0] hi,
			input logic [63:0] seed, input bit drain);
		gen_req_t r;
		r.op = op;
		r.lo = lo;
		r.hi = hi;
		r.seed = seed;
		r.drain = drain;
		request_queue.insert(request_queue.size(), r);
	endtask

	// driver
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (request_queue.size() != 0 &&
					!(request_queue[0].drain && pending_answers.size() != 0) &&
					(calm || $urandom_range(0, 99) >= 22)) begin
				in_valid <= 1'b1;
				func <= request_queue[0].op;
				range_low <= request_queue[0].lo;
				range_high <= request_queue[0].hi;
				load_value <= request_queue[0].seed;
				void'(request_queue.pop_front());
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		out_stall <= !calm && ($urandom_range(0, 99) < 22);
	end

	// monitor and checker
	always @(posedge clk) begin
		answer_t want;
		cycles++;
		if (cycles >= MAX_CYCLES) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				pending_answers.size());
			$display("[splitmix64_range_generator] ERROR");
			$finish;
		end else begin
			in_taken = arst_n && in_valid && !in_stall;
			if (in_taken) begin
				pending_answers.insert(pending_answers.size(),
					answer_for(func, range_low, range_high, load_value));
				n_accepted++;
				n_op[func]++;
				if (func == F_RANGE && range_high < range_low)
					n_range_err++;
			end
			if (arst_n && out_valid && !out_stall) begin
				if (pending_answers.size() == 0) begin
					errors++;
					$display("%0t unexpected result: expected none, actual value %h error %b",
						$time, result_value, range_error);
				end else begin
					want = pending_answers.pop_front();
					n_checked++;
					if (result_value !== want.value) begin
						errors++;
						$display("%0t result_value mismatch: expected %h actual %h",
							$time, want.value, result_value);
					end
					if (range_error !== want.err) begin
						errors++;
						$display("%0t range_error mismatch: expected %b actual %b",
							$time, want.err, range_error);
					end
				end
			end
		end
	end

	initial begin
		logic [63:0] rej_seed;
		logic [63:0] z;
		logic [31:0] lo;
		logic [31:0] hi;
		logic [31:0] t;
		logic [63:0] seed;
		int          kind;

		// state whose next draw is all ones, so any range draw redraws at least once
		z = unshift(ALL_ONES, 31);
		z = z * odd_inverse(MIX_B);
		z = unshift(z, 27);
		z = z * odd_inverse(MIX_A);
		z = unshift(z, 30);
		rej_seed = z - STEP_INC;

		add_req(F_RAW, $urandom, $urandom, {$urandom, $urandom}, 1'b0);
		add_req(F_UNIT, $urandom, $urandom, {$urandom, $urandom}, 1'b0);
		add_req(F_RANGE, 32'd0, 32'hFFFFFFFF, {$urandom, $urandom}, 1'b0);
		add_req(F_RANGE, 32'hFFFFFFFF, 32'hFFFFFFFF, {$urandom, $urandom}, 1'b0);
		add_req(F_RANGE, 32'd0, 32'd0, {$urandom, $urandom}, 1'b0);
		add_req(F_RANGE, 32'd1, 32'd0, {$urandom, $urandom}, 1'b0);
		add_req(F_RANGE, 32'hFFFFFFFF, 32'd0, {$urandom, $urandom}, 1'b0);
		add_req(F_LOAD, $urandom, $urandom, ALL_ONES, 1'b0);
		add_req(F_RAW, 32'hFFFFFFFF, 32'hFFFFFFFF, 64'd0, 1'b0);
		add_req(F_LOAD, 32'hFFFFFFFF, 32'hFFFFFFFF, 64'd0, 1'b0);
		add_req(F_UNIT, 32'd0, 32'd0, ALL_ONES, 1'b0);
		add_req(F_LOAD, $urandom, $urandom, rej_seed, 1'b0);
		add_req(F_RANGE, 32'd0, 32'hFFFFFFFF, {$urandom, $urandom}, 1'b0);
		add_req(F_LOAD, $urandom, $urandom, rej_seed, 1'b0);
		add_req(F_RANGE, 32'd5, 32'd7, {$urandom, $urandom}, 1'b0);
		add_req(F_LOAD, $urandom, $urandom, rej_seed, 1'b0);
		add_req(F_UNIT, $urandom, $urandom, {$urandom, $urandom}, 1'b0);
		add_req(F_LOAD, $urandom, $urandom, rej_seed, 1'b0);
		add_req(F_RAW, $urandom, $urandom, {$urandom, $urandom}, 1'b0);
		add_req(F_RANGE, 32'h80000000, 32'hFFFFFFFF, {$urandom, $urandom}, 1'b0);
		add_req(F_RANGE, 32'h7FFFFFFF, 32'h80000000, {$urandom, $urandom}, 1'b0);

		for (int i = 0; i < 630; i++) begin
			lo = $urandom;
			hi = $urandom;
			seed = {$urandom, $urandom};
			kind = $urandom_range(0, 99);
			if (kind < 20) begin
				add_req(F_RAW, lo, hi, seed, i == 0 || i == 350);
			end else if (kind < 38) begin
				add_req(F_UNIT, lo, hi, seed, i == 0 || i == 350);
			end else if (kind < 50) begin
				if ($urandom_range(0, 9) == 0)
					seed = rej_seed;
				add_req(F_LOAD, lo, hi, seed, i == 0 || i == 350);
			end else if (kind < 90) begin
				case ($urandom_range(0, 3))
					0: begin
						t = $urandom_range(0, 15);
						hi = (lo > 32'hFFFFFFFF - t) ? 32'hFFFFFFFF : lo + t;
					end
					1: begin
						if (lo > hi) begin
							t = lo;
							lo = hi;
							hi = t;
						end
					end
					2: begin
						lo = 32'd0;
					end
					default: begin
						if ($urandom_range(0, 1) == 0)
							lo = 32'd0;
						hi = 32'hFFFFFFFF;
					end
				endcase
				add_req(F_RANGE, lo, hi, seed, i == 0 || i == 350);
			end else begin
				if (lo == hi) begin
					if (lo == 32'd0)
						lo = 32'd1;
					else
						hi = lo - 32'd1;
				end else if (lo < hi) begin
					t = lo;
					lo = hi;
					hi = t;
				end
				add_req(F_RANGE, lo, hi, seed, i == 0 || i == 350);
			end
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (request_queue.size() != 0 || in_valid)
			@(posedge clk);
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("beats in %0d, results checked %0d in %0d cycles, %0d mismatches",
			n_accepted, n_checked, cycles, errors);
		$display("raw %0d, unit %0d, range %0d (%0d bad bounds, %0d redraws), load %0d",
			n_op[F_RAW], n_op[F_UNIT], n_op[F_RANGE], n_range_err, n_redraws, n_op[F_LOAD]);
		if (errors == 0 && pending_answers.size() == 0)
			$display("[splitmix64_range_generator] OK");
		else
			$display("[splitmix64_range_generator] ERROR");
		$finish;
	end

endmodule

/* filelist.f */
rtl/sm64_pkg.sv
rtl/splitmix64_range_generator.sv
dv/splitmix64_range_generator_tb.sv
